FILE: rtl/uleb_pkg.sv
// Shared types and constants for the strict unsigned LEB128 decoder.
package uleb_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int CHUNK_W        = 7;
    localparam int INDEX_W        = 4;
    localparam int COUNT_W        = 4;
    localparam int SHIFT_W        = INDEX_W + 3;
    localparam int CONT_BIT       = 7;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_NONCANON = 2'd2,
        ST_TRUNC    = 2'd3
    } status_t;

    typedef struct packed {
        logic                  emit;
        status_t               status;
        logic [COUNT_W-1:0]    byte_count;
        logic [INDEX_W-1:0]    next_index;
    } step_ctl_t;

endpackage

FILE: rtl/uleb_if.sv
// Valid/ready channel interfaces for encoded bytes and decoded results.
interface uleb_byte_if
    import uleb_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface uleb_result_if
    import uleb_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    status_t               status;
    logic [COUNT_W-1:0]    byte_count;

    modport source (output valid, output value, output status, output byte_count,
                    input ready);
    modport sink   (input valid, input value, input status, input byte_count,
                    output ready);
endinterface

FILE: rtl/uleb_step.sv
// Per-byte decode step: places the payload, checks the error cases, picks the result.
module uleb_step
    import uleb_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic [7:0]            data_byte,
    input  logic                  buffer_end,
    input  logic [VALUE_BITS-1:0] acc,
    input  logic [INDEX_W-1:0]    index,
    output logic [VALUE_BITS-1:0] acc_next,
    output logic [VALUE_BITS-1:0] value,
    output step_ctl_t             ctl
);
    localparam int WIDE = VALUE_BITS + CHUNK_W;

    logic [CHUNK_W-1:0] payload;
    logic               last;
    logic [SHIFT_W-1:0] shift;
    logic [WIDE-1:0]    placed;
    logic               overflow;
    logic               noncanon;
    logic [VALUE_BITS-1:0] merged;

    always_comb
    begin
        payload  = data_byte[CHUNK_W-1:0];
        last     = !data_byte[CONT_BIT];
        // 7 * index as 8 * index - index
        shift    = {index, 3'b000} - {3'b000, index};
        placed   = WIDE'(payload) << shift;
        overflow = (shift >= SHIFT_W'(VALUE_BITS)) || (|placed[WIDE-1:VALUE_BITS]);
        noncanon = last && (shift != '0) && (payload == '0);
        merged   = acc | placed[VALUE_BITS-1:0];

        ctl.byte_count = COUNT_W'(index) + COUNT_W'(1);
        ctl.emit       = 1'b1;
        ctl.status     = ST_OK;
        ctl.next_index = '0;
        value          = '0;
        acc_next       = '0;

        if (overflow)
        begin
            ctl.status = ST_OVERFLOW;
        end
        else if (noncanon)
        begin
            ctl.status = ST_NONCANON;
        end
        else if (last)
        begin
            value = merged;
        end
        else if (buffer_end)
        begin
            ctl.status = ST_TRUNC;
        end
        else
        begin
            ctl.emit       = 1'b0;
            ctl.next_index = index + INDEX_W'(1);
            acc_next       = merged;
        end
    end
endmodule

FILE: rtl/uleb128_strict_decoder_unit.sv
// Top level of the strict unsigned LEB128 decoder.
// A result is stored the cycle after its ending byte is accepted. Throughput: one
// byte per cycle unless stalled; the accumulator update is a single shift-OR pass.
// The byte channel stays ready while a held result is being taken in the same cycle.
// Reset clears the accumulator, byte index and output valid; no clearing pass.
module uleb128_strict_decoder_unit
    import uleb_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    uleb_byte_if.sink     bytes,
    uleb_result_if.source results
);
    localparam int MAX_INDEX = (VALUE_BITS + CHUNK_W - 1) / CHUNK_W;

    logic [VALUE_BITS-1:0] acc_reg;
    logic [INDEX_W-1:0]    index_reg;
    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] value_reg;
    status_t               status_reg;
    logic [COUNT_W-1:0]    count_reg;

    logic [VALUE_BITS-1:0] acc_next;
    logic [VALUE_BITS-1:0] step_value;
    step_ctl_t             ctl;
    logic                  accept;

    uleb_step #(
        .VALUE_BITS (VALUE_BITS)
    ) u_step (
        .data_byte  (bytes.data_byte),
        .buffer_end (bytes.buffer_end),
        .acc        (acc_reg),
        .index      (index_reg),
        .acc_next   (acc_next),
        .value      (step_value),
        .ctl        (ctl)
    );

    assign bytes.ready = !out_valid_reg || results.ready;
    assign accept      = bytes.valid && bytes.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            index_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                acc_reg   <= acc_next;
                index_reg <= ctl.next_index;
            end
            if (accept && ctl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && ctl.emit)
        begin
            value_reg  <= step_value;
            status_reg <= ctl.status;
            count_reg  <= ctl.byte_count;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.value      = value_reg;
    assign results.status     = status_reg;
    assign results.byte_count = count_reg;

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        index_reg <= INDEX_W'(MAX_INDEX))
        else $error("byte index past last chunk");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_OK) |-> (value_reg == '0))
        else $error("error result carries nonzero value");

    a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !bytes.data_byte[CONT_BIT]) |=> out_valid_reg)
        else $error("ending byte gave no result");

    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ctl.emit) |=> (count_reg == COUNT_W'($past(index_reg)) + COUNT_W'(1)))
        else $error("byte count does not match index");
endmodule
